@@ design/spl_pkg.sv @@
// ----------------------------------------------------------------------------
// spl_pkg
// shared sizes, codes and the command/status bundles of the sorted list
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_BITS + CNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    ins;
    logic    del;
    logic    push;
    logic    rd_entry;
    logic    rd_clr;
    logic    rd_inc;
    status_t status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic space;
    logic empty;
    logic full;
    logic found;
    logic rd_last;
  } sts_t;

  // one result transaction
  typedef struct packed {
    status_t                status;
    logic [VALUE_BITS-1:0]  entry;
    logic [CNT_W-1:0]       count;
    logic                   last;
  } res_t;

endpackage

@@ design/spl_ctrl.sv @@
// ----------------------------------------------------------------------------
// spl_ctrl
// operation decode and readout sequencer
// ----------------------------------------------------------------------------
module spl_ctrl import spl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  op_t  op,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_tready = (state_r == S_IDLE) && sts.space;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && op == OP_READ && !sts.empty) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (sts.space && sts.rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_INSERT: begin
              cmd.push   = 1'b1;
              cmd.ins    = !sts.full;
              cmd.status = sts.full ? ST_OVERFLOW : ST_OK;
            end
            OP_DELETE: begin
              cmd.push = 1'b1;
              cmd.del  = sts.found;
              if (sts.empty) begin
                cmd.status = ST_EMPTY;
              end else if (!sts.found) begin
                cmd.status = ST_NOT_FOUND;
              end
            end
            OP_READ: begin
              if (sts.empty) begin
                cmd.push   = 1'b1;
                cmd.status = ST_EMPTY;
              end else begin
                cmd.rd_clr = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (sts.space) begin
          cmd.push     = 1'b1;
          cmd.rd_entry = 1'b1;
          cmd.rd_inc   = !sts.rd_last;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/spl_dp.sv @@
// ----------------------------------------------------------------------------
// spl_dp
// sorted cell chain, entry count, readout index and two-deep result queue
// ----------------------------------------------------------------------------
module spl_dp import spl_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [VALUE_BITS-1:0] value,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output res_t                         out_res
);

  logic signed [VALUE_BITS-1:0] e_r     [DEPTH];
  logic signed [VALUE_BITS-1:0] ins_val [DEPTH];
  logic signed [VALUE_BITS-1:0] del_val [DEPTH];
  logic [DEPTH-1:0]             at_ins;
  logic [DEPTH-1:0]             at_del;
  logic [DEPTH-1:0]             eq;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [IDX_W-1:0]             rd_idx_r;
  res_t                         res;
  res_t                         head_r, head_nxt, tail_r, tail_nxt;
  logic                         hv_r, hv_nxt, tv_r, tv_nxt;
  logic                         pop;

  // per-cell compare; the list is descending so both masks are monotone
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic [CNT_W-1:0] KC = CNT_W'(k);
    assign at_ins[k] = (KC >= count_r) || (value >= e_r[k]);
    assign at_del[k] = (KC >= count_r) || (e_r[k] <= value);
    assign eq[k]     = (KC < count_r) && (e_r[k] == value);
    if (k == 0) begin : g_first
      assign ins_val[k] = at_ins[k] ? value : e_r[k];
    end else begin : g_rest
      assign ins_val[k] = !at_ins[k] ? e_r[k] : (at_ins[k-1] ? e_r[k-1] : value);
    end
    if (k == DEPTH - 1) begin : g_tail
      assign del_val[k] = e_r[k];
    end else begin : g_body
      assign del_val[k] = at_del[k] ? e_r[k+1] : e_r[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      if (cmd.ins) begin
        e_r[k] <= ins_val[k];
      end else if (cmd.del) begin
        e_r[k] <= del_val[k];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_idx_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.rd_clr) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_inc) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
    end
  end

  assign sts.empty   = (count_r == '0);
  assign sts.full    = (count_r >= CNT_W'(DEPTH));
  assign sts.found   = |eq;
  assign sts.rd_last = (CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r;
  assign sts.space   = !tv_r || out_tready;

  always_comb begin
    res.status = cmd.status;
    res.entry  = cmd.rd_entry ? e_r[rd_idx_r] : '0;
    res.count  = count_nxt;
    res.last   = cmd.rd_entry ? sts.rd_last : 1'b1;
  end

  // two-entry result queue: head drives the port
  assign pop = hv_r && out_tready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    hv_nxt   = hv_r;
    tv_nxt   = tv_r;
    if (pop) begin
      head_nxt = tail_r;
      hv_nxt   = tv_r;
      tv_nxt   = 1'b0;
    end
    if (cmd.push) begin
      if (!hv_nxt) begin
        head_nxt = res;
        hv_nxt   = 1'b1;
      end else begin
        tail_nxt = res;
        tv_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    if (!rst_n) begin
      hv_r <= 1'b0;
      tv_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
      tv_r <= tv_nxt;
    end
  end

  assign out_tvalid = hv_r;
  assign out_res    = head_r;

endmodule

@@ design/sorted_priority_list.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_list
// bounded list of signed values kept in descending order, with insert,
// delete-by-value and full readout
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  in_     | in  | in_tvalid/in_tready | tuser: op; tdata: value
//  out_    | out | out_tvalid/tready   | tuser: status; tdata: entry, count;
//          |     |                    | tlast: last result of a transaction
//
//  insert and delete are done in the cell chain at once: every cell compares
//  against the incoming value and loads its own value, a neighbor's or the new one
//  readout is accepted, then the single read index steps through the cells and
//  pushes one result per stored entry while the result queue has room (a single
//  result when the list is empty)
//  reset clears the entry count and the result queue; cell contents are not
//  cleared and need no pass, since only cells below the count are ever read
//  a two-deep result queue lets one finished result wait while the next input
//  transaction is taken; input stalls during readout and while the queue is full
// ----------------------------------------------------------------------------
module sorted_priority_list import spl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [VALUE_BITS-1:0] value
  input  logic [1:0]            in_tuser,   // [1:0] op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // entry, then stored_count, zero pad
  output logic [1:0]            out_tuser,  // [1:0] status
  output logic                  out_tlast   // last
);

  cmd_t                         cmd;
  sts_t                         sts;
  res_t                         out_res;
  logic signed [VALUE_BITS-1:0] value;
  op_t                          op;

  assign value = in_tdata[VALUE_BITS-1:0];
  assign op    = op_t'(in_tuser);

  // sequencer: decodes the op and steps the readout
  spl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .op        (op),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // cell chain, count and result queue
  spl_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tdata = OUT_DATA_W'({out_res.count, out_res.entry});
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.last;

  // a result is only queued when there is room for it
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.space)
    else $error("result pushed into a full queue");

  // insert never writes a full list
  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> !sts.full && cmd.status == ST_OK)
    else $error("insert on a full list");

  // once a readout starts, input is held off in the next cycle
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_clr |=> !in_tready)
    else $error("input taken during readout");

  // insert and delete never happen together
  a_one_edit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins && cmd.del))
    else $error("insert and delete in one cycle");

endmodule

@@ bench/spl_checker.sv @@
// ----------------------------------------------------------------------------
// spl_checker
// watches both streams of the sorted list, keeps its own ranked copy of the
// stored values and compares every result transaction field by field
// ----------------------------------------------------------------------------
module spl_checker import spl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  output int                    failures,
  output int                    pending
);

  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VALUE_BITS-1:0] ranked [DEPTH];
  int                           held;
  int                           mism;
  res_t                         due_q [$];

  initial begin
    held     = 0;
    mism     = 0;
    failures = 0;
    pending  = 0;
  end

  // update the ranked copy and queue the results one command causes
  function automatic void apply_cmd(logic [1:0] op, logic signed [VALUE_BITS-1:0] v);
    int   pos;
    res_t r;
    r.status = ST_OK;
    r.entry  = '0;
    r.last   = 1'b1;
    pos      = 0;
    case (op)
      OP_INSERT: begin
        if (held >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          // new value goes ahead of equal ones
          while (pos < held && v < ranked[pos]) pos++;
          for (int k = held; k > pos; k--) ranked[k] = ranked[k-1];
          ranked[pos] = v;
          held++;
        end
        r.count = CNT_W'(held);
        due_q.push_back(r);
      end
      OP_DELETE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          while (pos < held && ranked[pos] != v) pos++;
          if (pos == held) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (int k = pos; k + 1 < held; k++) ranked[k] = ranked[k+1];
            held--;
          end
        end
        r.count = CNT_W'(held);
        due_q.push_back(r);
      end
      OP_READ: begin
        r.count = CNT_W'(held);
        if (held == 0) begin
          r.status = ST_EMPTY;
          due_q.push_back(r);
        end else begin
          for (int k = 0; k < held; k++) begin
            r.entry = ranked[k];
            r.last  = (k == held - 1);
            due_q.push_back(r);
          end
        end
      end
      default: ;  // unused code: nothing happens
    endcase
  endfunction

  function automatic void check_result();
    res_t                  want;
    logic [VALUE_BITS-1:0] got_entry;
    logic [CNT_W-1:0]      got_count;
    got_entry = out_tdata[VALUE_BITS-1:0];
    got_count = out_tdata[VALUE_BITS +: CNT_W];
    if (due_q.size() == 0) begin
      $error("unexpected result: status %0d entry %0d stored_count %0d last %0b",
             out_tuser, $signed(got_entry), got_count, out_tlast);
      mism++;
    end else begin
      want = due_q.pop_front();
      if (out_tuser != want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_tuser);
        mism++;
      end
      if (got_entry != want.entry) begin
        $error("entry: expected %0d, got %0d", $signed(want.entry), $signed(got_entry));
        mism++;
      end
      if (got_count != want.count) begin
        $error("stored_count: expected %0d, got %0d", want.count, got_count);
        mism++;
      end
      if (out_tlast != want.last) begin
        $error("last: expected %0b, got %0b", want.last, out_tlast);
        mism++;
      end
    end
  endfunction

  // input side first, so a result leaving in the same cycle still meets its
  // expectation at the head of the queue
  always @(posedge clk) begin
    if (!rst_n) begin
      held = 0;
      due_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        apply_cmd(in_tuser, $signed(in_tdata[VALUE_BITS-1:0]));
      if (out_tvalid && out_tready)
        check_result();
    end
    pending  <= due_q.size();
    failures <= mism;
  end

endmodule

@@ bench/tb_sorted_priority_list.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_priority_list
// drives insert, delete and readout commands into the sorted list with random
// gaps and back-pressure; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_sorted_priority_list;
  import spl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // code with no operation behind it, the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  localparam int RANDOM_CMDS = 220;
  localparam int DRAIN_LIMIT = 100000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  int failures;
  int pending;

  always #4 clk = ~clk;

  sorted_priority_list u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [VALUE_BITS-1:0] value
    .in_tuser   (in_tuser),    // [1:0] op
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // entry, then stored_count, zero pad
    .out_tuser  (out_tuser),   // [1:0] status
    .out_tlast  (out_tlast)    // last
  );

  spl_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .failures   (failures),
    .pending    (pending)
  );

  // gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // values from a small pool repeat often, so deletes find their target;
  // the rest are fully random and toggle every bit
  function automatic logic signed [VALUE_BITS-1:0] pick_value(int pool_pct);
    if ($urandom_range(0, 99) >= pool_pct) return VALUE_BITS'($urandom);
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 7;
      6:       return 100;
      default: return -250;
    endcase
  endfunction

  // present one command at the falling edge and hold it until accepted
  task automatic send_cmd(logic [1:0] op, logic signed [VALUE_BITS-1:0] v);
    @(negedge clk);
    in_tvalid                  = 1'b1;
    in_tuser                   = op;
    in_tdata                   = '0;
    in_tdata[VALUE_BITS-1:0]   = v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // drop valid, with junk on the data lines; n sets the length of the gap
  task automatic pause_in(int n);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      in_tuser  = 2'($urandom);
      in_tdata  = IN_DATA_W'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold off until the checker has seen every expected result
  task automatic wait_drained();
    int guard;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < DRAIN_LIMIT);
  endtask

  // receiver: random stalls, with quiet stretches where it never stalls
  int  rx_hold  = 0;
  int  rx_cycle = 0;
  bit  rx_burst = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (rx_hold > 0) begin
        out_tready = 1'b0;
        rx_hold--;
      end else begin
        out_tready = 1'b1;
        if (!rx_burst) rx_hold = pick_gap();
      end
    end
  end

  // overall limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [1:0]                   op;
    logic signed [VALUE_BITS-1:0] v;
    int                           done;
    int                           r;
    bit                           filling;
    bit                           tx_burst;
    bit                           paused;

    done   = 0;
    paused = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed part ----
    send_cmd(OP_READ, 0);              // readout of an empty list
    send_cmd(OP_DELETE, 0);            // delete from an empty list
    send_cmd(OP_UNUSED, 16'sh1234);    // ignored code, no result
    send_cmd(OP_INSERT, 0);
    send_cmd(OP_INSERT, VAL_MAX);
    send_cmd(OP_INSERT, VAL_MIN);
    send_cmd(OP_INSERT, 5);
    send_cmd(OP_INSERT, 5);            // equal value goes ahead of the old one
    send_cmd(OP_INSERT, -1);
    send_cmd(OP_DELETE, 1234);         // no such entry
    send_cmd(OP_DELETE, 5);
    send_cmd(OP_READ, 0);
    // fill up to the depth, then one insert too many
    repeat (DEPTH - 5) begin
      send_cmd(OP_INSERT, pick_value(30));
      pause_in(pick_gap());
    end
    send_cmd(OP_INSERT, 42);           // overflow, list unchanged
    send_cmd(OP_READ, 0);              // full readout
    send_cmd(OP_DELETE, VAL_MIN);      // tail entry
    send_cmd(OP_DELETE, VAL_MAX);      // head entry

    // ---- random part ----
    // alternating fill-heavy and drain-heavy phases reach full and empty
    while (done < RANDOM_CMDS) begin
      filling  = ((done / 40) % 2 == 0);
      tx_burst = ((done / 30) % 4 == 3);

      // at least once, let every outstanding result come out first
      if (done == RANDOM_CMDS / 2 && !paused) begin
        paused = 1'b1;
        pause_in(1);
        wait_drained();
      end

      r = $urandom_range(0, 99);
      if (filling)
        op = (r < 65) ? OP_INSERT : (r < 82) ? OP_DELETE : (r < 95) ? OP_READ : OP_UNUSED;
      else
        op = (r < 65) ? OP_DELETE : (r < 80) ? OP_INSERT : (r < 95) ? OP_READ : OP_UNUSED;
      v = pick_value(filling ? 40 : 85);

      send_cmd(op, v);
      if (op != OP_UNUSED) done++;
      if (!tx_burst) pause_in(pick_gap());
    end

    pause_in(1);
    wait_drained();
    repeat (20) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sorted_priority_list.f @@
design/spl_pkg.sv
design/spl_ctrl.sv
design/spl_dp.sv
design/sorted_priority_list.sv
bench/spl_checker.sv
bench/tb_sorted_priority_list.sv
